[rtl/fpp_pkg.sv]
// ----------------------------------------------------------------------------
// FEN position parser package
// Shared constants, character codes, field codes and the piece letter lookup.
// ----------------------------------------------------------------------------
package fpp_pkg;

  // Default width of the half-move and full-move counters.
  localparam int COUNTER_WIDTH = 16;

  // Board and output word layout.
  localparam int NUM_BOARDS = 12;
  localparam int NUM_WORDS  = 16;
  localparam int WORD_BITS  = 64;

  localparam logic [3:0] WORD_WHITE  = 4'd12;
  localparam logic [3:0] WORD_BLACK  = 4'd13;
  localparam logic [3:0] WORD_ALL    = 4'd14;
  localparam logic [3:0] WORD_STATUS = 4'd15;

  // Square handling.
  localparam logic [7:0] START_SQUARE = 8'd56;
  localparam logic [7:0] RANK_STEP    = 8'd16;
  localparam logic [6:0] NO_SQUARE    = 7'd64;
  localparam logic [6:0] BAD_SQUARE   = 7'd127;

  // Character codes.
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_EIGHT = 8'h38;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_FILE_A = 8'h61;
  localparam logic [7:0] CHAR_FILE_H = 8'h68;
  localparam logic [7:0] CHAR_WK = 8'h4B;
  localparam logic [7:0] CHAR_WQ = 8'h51;
  localparam logic [7:0] CHAR_WB = 8'h42;
  localparam logic [7:0] CHAR_WN = 8'h4E;
  localparam logic [7:0] CHAR_WP = 8'h50;
  localparam logic [7:0] CHAR_WR = 8'h52;
  localparam logic [7:0] CHAR_BK = 8'h6B;
  localparam logic [7:0] CHAR_BQ = 8'h71;
  localparam logic [7:0] CHAR_BB = 8'h62;
  localparam logic [7:0] CHAR_BN = 8'h6E;
  localparam logic [7:0] CHAR_BP = 8'h70;
  localparam logic [7:0] CHAR_BR = 8'h72;

  // Castling flag positions.
  localparam int CASTLE_WK = 0;
  localparam int CASTLE_WQ = 1;
  localparam int CASTLE_BK = 2;
  localparam int CASTLE_BQ = 3;

  // Fields of the FEN string, in order of appearance.
  typedef enum logic [2:0] {
    FIELD_PIECES,
    FIELD_SIDE,
    FIELD_CASTLE,
    FIELD_PASSANT,
    FIELD_HALFMOVE,
    FIELD_FULLMOVE,
    FIELD_EXTRA
  } field_t;

  // Result of looking up a piece letter.
  typedef struct packed {
    logic       hit;
    logic [3:0] board;
  } piece_hit_t;

  // Map a character to its board index, WP WN WB WR WQ WK BP BN BB BR BQ BK.
  function automatic piece_hit_t piece_lookup(input logic [7:0] c);
    piece_hit_t r;
    r.hit = 1'b1;
    case (c)
      CHAR_WP: r.board = 4'd0;
      CHAR_WN: r.board = 4'd1;
      CHAR_WB: r.board = 4'd2;
      CHAR_WR: r.board = 4'd3;
      CHAR_WQ: r.board = 4'd4;
      CHAR_WK: r.board = 4'd5;
      CHAR_BP: r.board = 4'd6;
      CHAR_BN: r.board = 4'd7;
      CHAR_BB: r.board = 4'd8;
      CHAR_BR: r.board = 4'd9;
      CHAR_BQ: r.board = 4'd10;
      CHAR_BK: r.board = 4'd11;
      default: begin
        r.hit   = 1'b0;
        r.board = 4'd0;
      end
    endcase
    return r;
  endfunction

endpackage

[rtl/fpp_input_reg.sv]
// ----------------------------------------------------------------------------
// FEN parser input register
// Holds one character transfer until the position state takes it.
// ----------------------------------------------------------------------------
module fpp_input_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] char_code,
  input  logic       end_of_string,
  input  logic       advance,
  output logic       item_valid,
  output logic [7:0] item_char,
  output logic       item_eos
);

  logic take;

  // The register accepts a new transfer when it is empty or its item moves on.
  assign char_stall = item_valid & ~advance;
  assign take       = char_valid & ~char_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      item_char <= char_code;
      item_eos  <= end_of_string;
    end
  end

endmodule

[rtl/fpp_state.sv]
// ----------------------------------------------------------------------------
// FEN parser position state
// Applies one character to the position and hands the final position over.
// ----------------------------------------------------------------------------
module fpp_state #(
  parameter int COUNTER_WIDTH = fpp_pkg::COUNTER_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  input  logic [7:0]                           item_char,
  input  logic                                 item_eos,
  input  logic                                 snap_free,
  output logic                                 advance,
  output logic                                 load,
  output logic [fpp_pkg::NUM_BOARDS-1:0][63:0] boards_next,
  output logic                                 black_next,
  output logic [3:0]                           castle_next,
  output logic [6:0]                           passant_next,
  output logic [COUNTER_WIDTH-1:0]             halfmove_next,
  output logic [COUNTER_WIDTH-1:0]             fullmove_next
);

  localparam logic [COUNTER_WIDTH-1:0] CountMax = '1;

  logic [fpp_pkg::NUM_BOARDS-1:0][63:0] boards;
  logic [7:0]                           square;
  logic [7:0]                           square_next;
  fpp_pkg::field_t                      field;
  fpp_pkg::field_t                      field_next;
  logic                                 in_word;
  logic                                 in_word_next;
  logic                                 black;
  logic [3:0]                           castle;
  logic [6:0]                           passant;
  logic [COUNTER_WIDTH-1:0]             halfmove;
  logic [COUNTER_WIDTH-1:0]             fullmove;

  logic                                 is_digit;
  logic                                 first;
  fpp_pkg::piece_hit_t                  piece;
  logic [7:0]                           file_ofs;
  logic [7:0]                           rank_ofs;

  // Append one decimal digit, saturating at the counter's top value.
  function automatic logic [COUNTER_WIDTH-1:0] add_digit(
    input logic [COUNTER_WIDTH-1:0] count,
    input logic [3:0]               digit
  );
    logic [COUNTER_WIDTH+3:0] wide;
    wide = ({4'b0, count} << 3) + ({4'b0, count} << 1) + (COUNTER_WIDTH + 4)'(digit);
    if (wide > (COUNTER_WIDTH + 4)'(CountMax)) begin
      return CountMax;
    end
    return wide[COUNTER_WIDTH-1:0];
  endfunction

  // An item moves on unless it ends a string while the snapshot is still busy.
  assign advance = item_valid & (~item_eos | snap_free);
  assign load    = advance & item_eos;

  assign is_digit = item_char inside {[fpp_pkg::CHAR_ZERO:fpp_pkg::CHAR_NINE]};
  assign first    = ~in_word;
  assign piece    = fpp_pkg::piece_lookup(item_char);
  assign file_ofs = item_char - fpp_pkg::CHAR_FILE_A;
  assign rank_ofs = item_char - fpp_pkg::CHAR_ONE;

  // Next position after the character held in the input register.
  always_comb begin
    boards_next   = boards;
    square_next   = square;
    field_next    = field;
    in_word_next  = in_word;
    black_next    = black;
    castle_next   = castle;
    passant_next  = passant;
    halfmove_next = halfmove;
    fullmove_next = fullmove;
    if (item_char == fpp_pkg::CHAR_SPACE) begin
      // A run of spaces closes the current field.
      if (in_word) begin
        in_word_next = 1'b0;
        if (field != fpp_pkg::FIELD_EXTRA) begin
          field_next = fpp_pkg::field_t'(field + 3'd1);
        end
      end
    end else begin
      in_word_next = 1'b1;
      case (field)
        fpp_pkg::FIELD_PIECES: begin
          if (piece.hit) begin
            if (square[7:6] == 2'b00) begin
              boards_next[piece.board][square[5:0]] = 1'b1;
            end
            square_next = square + 8'd1;
          end else if (item_char == fpp_pkg::CHAR_SLASH) begin
            square_next = square - fpp_pkg::RANK_STEP;
          end else if (is_digit) begin
            square_next = square + {4'b0, item_char[3:0]};
          end
        end
        fpp_pkg::FIELD_SIDE: begin
          if (first) begin
            black_next = (item_char == fpp_pkg::CHAR_BB);
          end
        end
        fpp_pkg::FIELD_CASTLE: begin
          case (item_char)
            fpp_pkg::CHAR_WK: castle_next[fpp_pkg::CASTLE_WK] = 1'b1;
            fpp_pkg::CHAR_WQ: castle_next[fpp_pkg::CASTLE_WQ] = 1'b1;
            fpp_pkg::CHAR_BK: castle_next[fpp_pkg::CASTLE_BK] = 1'b1;
            fpp_pkg::CHAR_BQ: castle_next[fpp_pkg::CASTLE_BQ] = 1'b1;
            default: ;
          endcase
        end
        fpp_pkg::FIELD_PASSANT: begin
          // The first character picks a file, the second a rank.
          if (first) begin
            if (item_char inside {[fpp_pkg::CHAR_FILE_A:fpp_pkg::CHAR_FILE_H]}) begin
              passant_next = {4'b1000, file_ofs[2:0]};
            end else begin
              passant_next = fpp_pkg::BAD_SQUARE;
            end
          end else if (passant[6:3] == 4'b1000) begin
            if (item_char inside {[fpp_pkg::CHAR_ONE:fpp_pkg::CHAR_EIGHT]}) begin
              passant_next = {1'b0, rank_ofs[2:0], passant[2:0]};
            end else begin
              passant_next = fpp_pkg::BAD_SQUARE;
            end
          end
        end
        fpp_pkg::FIELD_HALFMOVE: begin
          if (is_digit) begin
            halfmove_next = add_digit(halfmove, item_char[3:0]);
          end
        end
        fpp_pkg::FIELD_FULLMOVE: begin
          if (is_digit) begin
            fullmove_next = add_digit(fullmove, item_char[3:0]);
          end
        end
        default: ;
      endcase
    end
  end

  // State registers; the last character of a string returns them to reset.
  always_ff @(posedge clk) begin
    if (rst || load) begin
      boards   <= '0;
      square   <= fpp_pkg::START_SQUARE;
      field    <= fpp_pkg::FIELD_PIECES;
      in_word  <= 1'b0;
      black    <= 1'b0;
      castle   <= 4'd0;
      passant  <= fpp_pkg::NO_SQUARE;
      halfmove <= '0;
      fullmove <= '0;
    end else if (advance) begin
      boards   <= boards_next;
      square   <= square_next;
      field    <= field_next;
      in_word  <= in_word_next;
      black    <= black_next;
      castle   <= castle_next;
      passant  <= passant_next;
      halfmove <= halfmove_next;
      fullmove <= fullmove_next;
    end
  end

endmodule

[rtl/fpp_emitter.sv]
// ----------------------------------------------------------------------------
// FEN parser word emitter
// Holds a snapshot of the final position and sends it out as 16 words.
// ----------------------------------------------------------------------------
module fpp_emitter #(
  parameter int COUNTER_WIDTH = fpp_pkg::COUNTER_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  logic [fpp_pkg::NUM_BOARDS-1:0][63:0] boards_in,
  input  logic                                 black_in,
  input  logic [3:0]                           castle_in,
  input  logic [6:0]                           passant_in,
  input  logic [COUNTER_WIDTH-1:0]             halfmove_in,
  input  logic [COUNTER_WIDTH-1:0]             fullmove_in,
  output logic                                 snap_free,
  output logic                                 word_valid,
  input  logic                                 word_stall,
  output logic [3:0]                           word_index,
  output logic [63:0]                          word_value,
  output logic                                 last_word
);

  logic [fpp_pkg::NUM_BOARDS-1:0][63:0] snap_boards;
  logic                                 snap_black;
  logic [3:0]                           snap_castle;
  logic [6:0]                           snap_passant;
  logic [COUNTER_WIDTH-1:0]             snap_halfmove;
  logic [COUNTER_WIDTH-1:0]             snap_fullmove;
  logic                                 busy;
  logic [3:0]                           count;
  logic                                 fire;
  logic [63:0]                          white;
  logic [63:0]                          black;
  logic [6:0]                           ep;
  logic [2*COUNTER_WIDTH+11:0]          status_wide;

  assign fire       = busy & ~word_stall;
  assign word_valid = busy;
  assign word_index = count;
  assign last_word  = (count == fpp_pkg::WORD_STATUS);
  // A new snapshot may enter in the cycle the last word leaves.
  assign snap_free  = ~busy | (fire & last_word);

  // Word sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= 4'd0;
    end else if (load) begin
      busy  <= 1'b1;
      count <= 4'd0;
    end else if (fire) begin
      if (last_word) begin
        busy <= 1'b0;
      end
      count <= count + 4'd1;
    end
  end

  // Snapshot of the final position.
  always_ff @(posedge clk) begin
    if (load) begin
      snap_boards   <= boards_in;
      snap_black    <= black_in;
      snap_castle   <= castle_in;
      snap_passant  <= passant_in;
      snap_halfmove <= halfmove_in;
      snap_fullmove <= fullmove_in;
    end
  end

  // Color summaries and the status word.
  always_comb begin
    white = '0;
    black = '0;
    for (int i = 0; i < fpp_pkg::NUM_BOARDS / 2; i++) begin
      white = white | snap_boards[i];
      black = black | snap_boards[i + fpp_pkg::NUM_BOARDS / 2];
    end
    ep          = snap_passant[6] ? fpp_pkg::NO_SQUARE : snap_passant;
    status_wide = {snap_fullmove, snap_halfmove, ep, snap_castle, snap_black};
  end

  // Word selection by index.
  always_comb begin
    case (count)
      fpp_pkg::WORD_WHITE:  word_value = white;
      fpp_pkg::WORD_BLACK:  word_value = black;
      fpp_pkg::WORD_ALL:    word_value = white | black;
      fpp_pkg::WORD_STATUS: word_value = 64'(status_wide);
      default:              word_value = snap_boards[count];
    endcase
  end

endmodule

[rtl/fen_position_parser.sv]
// With no earlier run pending, a string's final character is captured in the input register
// and then loads the snapshot that offers the words; the first word can transfer as soon as offered.
// Throughput: one character per cycle while char_stall is low; the 16 words leave one per
// cycle while word_stall is low. The next string's characters are taken meanwhile, only its
// final character waiting until the last run of words has left (the snapshot is the limit).
// Reset: synchronous, active high; clears the position and drops any pending words.
// ----------------------------------------------------------------------------
// FEN position parser
// Parses a FEN string one character per transfer into twelve piece boards,
// summaries and a status word, sent as 16 words after the final character.
// ----------------------------------------------------------------------------
module fen_position_parser #(
  parameter int COUNTER_WIDTH = fpp_pkg::COUNTER_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  logic [7:0]  char_code,
  input  logic        end_of_string,
  output logic        word_valid,
  input  logic        word_stall,
  output logic [3:0]  word_index,
  output logic [63:0] word_value,
  output logic        last_word
);

  logic                                 advance;
  logic                                 load;
  logic                                 snap_free;
  logic                                 item_valid;
  logic [7:0]                           item_char;
  logic                                 item_eos;
  logic [fpp_pkg::NUM_BOARDS-1:0][63:0] boards_next;
  logic                                 black_next;
  logic [3:0]                           castle_next;
  logic [6:0]                           passant_next;
  logic [COUNTER_WIDTH-1:0]             halfmove_next;
  logic [COUNTER_WIDTH-1:0]             fullmove_next;

  // Input register.
  fpp_input_reg u_input (
    .clk           (clk),
    .rst           (rst),
    .char_valid    (char_valid),
    .char_stall    (char_stall),
    .char_code     (char_code),
    .end_of_string (end_of_string),
    .advance       (advance),
    .item_valid    (item_valid),
    .item_char     (item_char),
    .item_eos      (item_eos)
  );

  // Position state and its update.
  fpp_state #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_state (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_char     (item_char),
    .item_eos      (item_eos),
    .snap_free     (snap_free),
    .advance       (advance),
    .load          (load),
    .boards_next   (boards_next),
    .black_next    (black_next),
    .castle_next   (castle_next),
    .passant_next  (passant_next),
    .halfmove_next (halfmove_next),
    .fullmove_next (fullmove_next)
  );

  // Snapshot and word output.
  fpp_emitter #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_emitter (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .boards_in   (boards_next),
    .black_in    (black_next),
    .castle_in   (castle_next),
    .passant_in  (passant_next),
    .halfmove_in (halfmove_next),
    .fullmove_in (fullmove_next),
    .snap_free   (snap_free),
    .word_valid  (word_valid),
    .word_stall  (word_stall),
    .word_index  (word_index),
    .word_value  (word_value),
    .last_word   (last_word)
  );

endmodule

[rtl/fpp_checker.sv]
// ----------------------------------------------------------------------------
// FEN parser port checker
// Watches the top level's ports for ordering and handshake slips.
// ----------------------------------------------------------------------------
module fpp_checker (
  input logic        clk,
  input logic        rst,
  input logic        char_valid,
  input logic        char_stall,
  input logic        end_of_string,
  input logic        word_valid,
  input logic        word_stall,
  input logic [3:0]  word_index,
  input logic [63:0] word_value,
  input logic        last_word
);

  // A stalled word holds its index and value.
  a_word_hold: assert property (@(posedge clk) disable iff (rst)
    word_valid && word_stall |=> word_valid && $stable(word_index) && $stable(word_value))
    else $error("stalled word changed");

  // The last-word flag marks the status word and only it.
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    word_valid |-> (last_word == (word_index == fpp_pkg::WORD_STATUS)))
    else $error("last_word does not match word_index");

  // Words of one run follow in index order without gaps.
  a_word_order: assert property (@(posedge clk) disable iff (rst)
    word_valid && !word_stall && !last_word |=>
      word_valid && (word_index == 4'($past(word_index) + 4'd1)))
    else $error("word run broken");

  // A final character taken while no words are pending starts a run soon after.
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_stall && end_of_string && !word_valid |=> ##1 word_valid)
    else $error("word run did not start");

  // Reset leaves no words pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !word_valid)
    else $error("word pending after reset");

endmodule

bind fen_position_parser fpp_checker u_fpp_checker (
  .clk           (clk),
  .rst           (rst),
  .char_valid    (char_valid),
  .char_stall    (char_stall),
  .end_of_string (end_of_string),
  .word_valid    (word_valid),
  .word_stall    (word_stall),
  .word_index    (word_index),
  .word_value    (word_value),
  .last_word     (last_word)
);

[tb/fen_position_parser_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FEN position parser testbench
// Feeds FEN strings one character per transfer: a table of directed strings,
// then random well-formed positions mixed with broken strings and raw noise.
// A behavioral parser in the testbench predicts the 16 words of every string,
// and each word taken from the block is compared field by field in order.
// ----------------------------------------------------------------------------
module fen_position_parser_tb;

  localparam int CNT_W = fpp_pkg::COUNTER_WIDTH;
  localparam longint unsigned CNT_MAX = (64'd1 << CNT_W) - 64'd1;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_STRINGS  = 2;
  localparam int DRAIN_CYCLES  = 40;
  localparam int DIRECTED_ROWS = 10;
  localparam int RANDOM_END    = 110;
  localparam int ITEM_TARGET   = 200;

  // Characters the package does not name.
  localparam logic [7:0] CHAR_WHITE_SIDE = 8'h77;
  localparam logic [7:0] CHAR_BLACK_SIDE = 8'h62;
  localparam logic [7:0] CHAR_DASH       = 8'h2D;

  typedef struct {
    logic [3:0]  idx;
    logic [63:0] bits;
    logic        last;
  } word_t;

  typedef struct {
    string       text;
    bit          typed;
    logic [63:0] status;
  } fen_case_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        char_valid = 1'b0;
  logic        char_stall;
  logic [7:0]  char_code = 8'd0;
  logic        end_of_string = 1'b0;
  logic        word_valid;
  logic        word_stall = 1'b0;
  logic [3:0]  word_index;
  logic [63:0] word_value;
  logic        last_word;

  // Board order of the piece letters, white then black.
  logic [7:0] piece_chars [12] = '{
    fpp_pkg::CHAR_WP, fpp_pkg::CHAR_WN, fpp_pkg::CHAR_WB,
    fpp_pkg::CHAR_WR, fpp_pkg::CHAR_WQ, fpp_pkg::CHAR_WK,
    fpp_pkg::CHAR_BP, fpp_pkg::CHAR_BN, fpp_pkg::CHAR_BB,
    fpp_pkg::CHAR_BR, fpp_pkg::CHAR_BQ, fpp_pkg::CHAR_BK
  };

  // Directed strings; the final character of each carries end_of_string.
  fen_case_t fen_cases [DIRECTED_ROWS] = '{
    '{" ",                         1'b1, 64'h0000_0000_0000_0800},
    '{"////8P",                    1'b0, 64'd0},
    '{"0x7Rq/9p",                  1'b0, 64'd0},
    '{"PNBRQKpnbrqk",              1'b0, 64'd0},
    '{"x b q a1 0 1",              1'b1, 64'h0000_0000_1000_0011},
    '{"x w KQkq h8 65535 99999 9", 1'b1, 64'h0000_0FFF_FFFF_F7FE},
    '{"x w - i3",                  1'b1, 64'h0000_0000_0000_0800},
    '{"x w - a9",                  1'b1, 64'h0000_0000_0000_0800},
    '{"x b - e",                   1'b1, 64'h0000_0000_0000_0801},
    '{"  k   b  ",                 1'b0, 64'd0}
  };

  // Predicted parser state.
  logic [63:0]      board_bits [12];
  logic [7:0]       cur_sq;
  fpp_pkg::field_t  cur_field;
  bit               in_token;
  bit               black_side;
  logic [3:0]       castle_bits;
  logic [6:0]       ep_sq;
  longint unsigned  half_cnt;
  longint unsigned  full_cnt;

  word_t      word_exp_q [$];
  logic [7:0] fen_chars [$];
  bit          pinned_on;
  logic [63:0] pinned_status;
  bit          idle_on;
  bit          tx_idle;
  bit          hold_req;
  bit          hold_on;
  int unsigned chars_sent;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  fen_position_parser #(
    .COUNTER_WIDTH(CNT_W)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_code    (char_code),
    .end_of_string(end_of_string),
    .word_valid   (word_valid),
    .word_stall   (word_stall),
    .word_index   (word_index),
    .word_value   (word_value),
    .last_word    (last_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clear the predicted position to its reset contents.
  function automatic void reset_position();
    foreach (board_bits[k]) board_bits[k] = 64'd0;
    cur_sq      = fpp_pkg::START_SQUARE;
    cur_field   = fpp_pkg::FIELD_PIECES;
    in_token    = 1'b0;
    black_side  = 1'b0;
    castle_bits = 4'd0;
    ep_sq       = fpp_pkg::NO_SQUARE;
    half_cnt    = 0;
    full_cnt    = 0;
  endfunction

  // One decimal digit into a saturating counter.
  function automatic longint unsigned add_digit(longint unsigned count, logic [7:0] c);
    longint unsigned v;
    if (c < fpp_pkg::CHAR_ZERO || c > fpp_pkg::CHAR_NINE) return count;
    v = count * 10 + longint'(c - fpp_pkg::CHAR_ZERO);
    return (v > CNT_MAX) ? CNT_MAX : v;
  endfunction

  // Advance the predicted position by one character.
  function automatic void apply_char(logic [7:0] c);
    bit first;
    bit hit;
    if (c == fpp_pkg::CHAR_SPACE) begin
      if (in_token) begin
        in_token = 1'b0;
        if (cur_field != fpp_pkg::FIELD_EXTRA) cur_field = fpp_pkg::field_t'(cur_field + 1);
      end
      return;
    end
    first    = !in_token;
    in_token = 1'b1;
    case (cur_field)
      fpp_pkg::FIELD_PIECES: begin
        hit = 1'b0;
        for (int k = 0; k < 12; k++) begin
          if (!hit && c == piece_chars[k]) begin
            if (cur_sq < 8'd64) board_bits[k][cur_sq[5:0]] = 1'b1;
            cur_sq = cur_sq + 8'd1;
            hit = 1'b1;
          end
        end
        if (!hit) begin
          if (c == fpp_pkg::CHAR_SLASH) begin
            cur_sq = cur_sq - fpp_pkg::RANK_STEP;
          end else if (c >= fpp_pkg::CHAR_ZERO && c <= fpp_pkg::CHAR_NINE) begin
            cur_sq = cur_sq + (c - fpp_pkg::CHAR_ZERO);
          end
        end
      end
      fpp_pkg::FIELD_SIDE: begin
        if (first) black_side = (c == CHAR_BLACK_SIDE);
      end
      fpp_pkg::FIELD_CASTLE: begin
        if (c == fpp_pkg::CHAR_WK) castle_bits[fpp_pkg::CASTLE_WK] = 1'b1;
        else if (c == fpp_pkg::CHAR_WQ) castle_bits[fpp_pkg::CASTLE_WQ] = 1'b1;
        else if (c == fpp_pkg::CHAR_BK) castle_bits[fpp_pkg::CASTLE_BK] = 1'b1;
        else if (c == fpp_pkg::CHAR_BQ) castle_bits[fpp_pkg::CASTLE_BQ] = 1'b1;
      end
      fpp_pkg::FIELD_PASSANT: begin
        // The file parks the square at 64 + file until the rank arrives.
        if (first) begin
          if (c >= fpp_pkg::CHAR_FILE_A && c <= fpp_pkg::CHAR_FILE_H)
            ep_sq = fpp_pkg::NO_SQUARE + 7'(c - fpp_pkg::CHAR_FILE_A);
          else
            ep_sq = fpp_pkg::BAD_SQUARE;
        end else if (ep_sq >= fpp_pkg::NO_SQUARE && ep_sq < fpp_pkg::NO_SQUARE + 7'd8) begin
          if (c >= fpp_pkg::CHAR_ONE && c <= fpp_pkg::CHAR_EIGHT)
            ep_sq = (ep_sq - fpp_pkg::NO_SQUARE) + 7'((c - fpp_pkg::CHAR_ONE) * 8);
          else
            ep_sq = fpp_pkg::BAD_SQUARE;
        end
      end
      fpp_pkg::FIELD_HALFMOVE: half_cnt = add_digit(half_cnt, c);
      fpp_pkg::FIELD_FULLMOVE: full_cnt = add_digit(full_cnt, c);
      default: ;
    endcase
  endfunction

  // Queue the 16 words of the finished string and start a new position.
  function automatic void push_words();
    logic [63:0] white;
    logic [63:0] black;
    logic [63:0] status;
    logic [6:0]  ep_out;
    word_t       w;
    white = 64'd0;
    black = 64'd0;
    for (int i = 0; i < 6; i++) begin
      white |= board_bits[i];
      black |= board_bits[i + 6];
    end
    ep_out = (ep_sq < fpp_pkg::NO_SQUARE) ? ep_sq : fpp_pkg::NO_SQUARE;
    status = {63'd0, black_side} | (64'(castle_bits) << 1) | (64'(ep_out) << 5)
           | ((half_cnt & CNT_MAX) << 12) | ((full_cnt & CNT_MAX) << (12 + CNT_W));
    if (pinned_on) status = pinned_status;
    pinned_on = 1'b0;
    for (int i = 0; i < fpp_pkg::NUM_WORDS; i++) begin
      w.idx = 4'(i);
      case (w.idx)
        fpp_pkg::WORD_WHITE:  w.bits = white;
        fpp_pkg::WORD_BLACK:  w.bits = black;
        fpp_pkg::WORD_ALL:    w.bits = white | black;
        fpp_pkg::WORD_STATUS: w.bits = status;
        default:              w.bits = board_bits[i];
      endcase
      w.last = (w.idx == fpp_pkg::WORD_STATUS);
      word_exp_q = {word_exp_q, w};
    end
    reset_position();
  endfunction

  // Append one character to the string being built.
  function automatic void queue_char(logic [7:0] c);
    fen_chars = {fen_chars, c};
  endfunction

  // Any byte except the field separator.
  function automatic logic [7:0] rand_glyph();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == fpp_pkg::CHAR_SPACE);
    return b;
  endfunction

  function automatic void push_num(int unsigned n);
    string s;
    s = $sformatf("%0d", n);
    for (int i = 0; i < s.len(); i++) queue_char(s[i]);
  endfunction

  // Build one random string: mostly well-formed positions with random content,
  // some with broken or missing fields, and some raw byte noise.
  function automatic void make_fen();
    int ranks;
    int fields;
    int fill;
    int d;
    int pick;
    fen_chars.delete();
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 20)) queue_char(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 7) == 0) queue_char(fpp_pkg::CHAR_SPACE);
    // Piece placement: a full board now and then, else a few top ranks.
    ranks = ($urandom_range(0, 3) == 0) ? 8 : $urandom_range(1, 3);
    for (int r = 0; r < ranks; r++) begin
      if (r != 0) queue_char(fpp_pkg::CHAR_SLASH);
      fill = 0;
      while (fill < 8) begin
        if ($urandom_range(0, 2) == 0) begin
          d = $urandom_range(1, 8 - fill);
          queue_char(fpp_pkg::CHAR_ZERO + 8'(d));
          fill += d;
        end else begin
          queue_char(piece_chars[$urandom_range(0, 11)]);
          fill++;
        end
      end
      pick = $urandom_range(0, 23);
      if (pick == 0) queue_char(fpp_pkg::CHAR_ZERO);
      else if (pick == 1) queue_char(fpp_pkg::CHAR_NINE);
      else if (pick == 2) queue_char(rand_glyph());
    end
    fields = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 5;
    for (int f = 1; f <= fields; f++) begin
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(2, 3) : 1)
        queue_char(fpp_pkg::CHAR_SPACE);
      case (fpp_pkg::field_t'(f))
        fpp_pkg::FIELD_SIDE: begin
          if ($urandom_range(0, 9) == 0) queue_char(rand_glyph());
          else queue_char($urandom_range(0, 1) ? CHAR_BLACK_SIDE : CHAR_WHITE_SIDE);
          if ($urandom_range(0, 9) == 0) queue_char(CHAR_BLACK_SIDE);
        end
        fpp_pkg::FIELD_CASTLE: begin
          d = fen_chars.size();
          if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 1)) queue_char(fpp_pkg::CHAR_WK);
            if ($urandom_range(0, 1)) queue_char(fpp_pkg::CHAR_WQ);
            if ($urandom_range(0, 1)) queue_char(fpp_pkg::CHAR_BK);
            if ($urandom_range(0, 1)) queue_char(fpp_pkg::CHAR_BQ);
            if ($urandom_range(0, 9) == 0) queue_char(rand_glyph());
          end
          if (fen_chars.size() == d) queue_char(CHAR_DASH);
        end
        fpp_pkg::FIELD_PASSANT: begin
          pick = $urandom_range(0, 11);
          if (pick < 4) begin
            queue_char(CHAR_DASH);
          end else begin
            if (pick == 9) queue_char(rand_glyph());
            else queue_char(fpp_pkg::CHAR_FILE_A + 8'($urandom_range(0, 7)));
            if (pick == 8) queue_char(rand_glyph());
            else if (pick != 10) queue_char(fpp_pkg::CHAR_ONE + 8'($urandom_range(0, 7)));
            if (pick == 11) queue_char(rand_glyph());
          end
        end
        fpp_pkg::FIELD_HALFMOVE, fpp_pkg::FIELD_FULLMOVE: begin
          pick = $urandom_range(0, 9);
          if (pick == 0) begin
            push_num($urandom_range(0, 9999999));
          end else if (pick == 1) begin
            queue_char(fpp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
            queue_char(rand_glyph());
            queue_char(fpp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
          end else begin
            push_num($urandom_range(0, 150));
          end
        end
        default: begin
          repeat ($urandom_range(1, 3)) queue_char(rand_glyph());
        end
      endcase
    end
    if ($urandom_range(0, 7) == 0) queue_char(fpp_pkg::CHAR_SPACE);
  endfunction

  // Offer one character and hold it until the transfer, then maybe go idle.
  task automatic send_char(input logic [7:0] code, input logic eos);
    char_valid    <= 1'b1;
    char_code     <= code;
    end_of_string <= eos;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    apply_char(code);
    if (eos) push_words();
    chars_sent++;
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      char_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic send_string();
    for (int i = 0; i < fen_chars.size(); i++)
      send_char(fen_chars[i], i == fen_chars.size() - 1);
  endtask

  task automatic report(input string msg);
    $display("%s", msg);
    mismatch_count++;
  endtask

  // Receiver: random stall bursts, quiet stretches, and one long hold-off.
  initial begin : word_sink
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_on = 1'b1;
        word_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        word_stall <= 1'b0;
        hold_req = 1'b0;
        hold_on  = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        word_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        word_stall <= 1'b0;
      end else if ($urandom_range(0, 60) == 0) begin
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end
    end
  end

  // Compare every word transfer with the oldest prediction.
  always @(posedge clk) begin : word_check
    word_t want;
    if (!rst && word_valid && !word_stall) begin
      if (word_exp_q.size() == 0) begin
        report($sformatf("%0t: unexpected word, index %0d value %h last %b",
                         $time, word_index, word_value, last_word));
      end else begin
        want = word_exp_q.pop_front();
        if (word_index !== want.idx)
          report($sformatf("%0t: word_index expected %0d actual %0d",
                           $time, want.idx, word_index));
        if (word_value !== want.bits)
          report($sformatf("%0t: word_value (word %0d) expected %h actual %h",
                           $time, want.idx, want.bits, word_value));
        if (last_word !== want.last)
          report($sformatf("%0t: last_word (word %0d) expected %b actual %b",
                           $time, want.idx, want.last, last_word));
      end
    end
  end

  // Cycle counter that ends a hung run.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout with %0d words outstanding", $time, word_exp_q.size());
    $display("fen_position_parser regression: fail");
    $finish;
  end

  initial begin : stimulus
    pinned_on      = 1'b0;
    idle_on        = 1'b1;
    tx_idle        = 1'b1;
    hold_req       = 1'b0;
    chars_sent     = 0;
    mismatch_count = 0;
    reset_position();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed strings.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      fen_chars.delete();
      for (int i = 0; i < fen_cases[r].text.len(); i++) queue_char(fen_cases[r].text[i]);
      pinned_on     = fen_cases[r].typed;
      pinned_status = fen_cases[r].status;
      tx_idle       = ($urandom_range(0, 3) != 0);
      send_string();
    end

    // Random strings with idling on both sides.
    while (chars_sent < RANDOM_END) begin
      make_fen();
      tx_idle = ($urandom_range(0, 3) != 0);
      send_string();
    end

    // Long receiver hold-off while strings keep coming, so the block backs up.
    char_valid <= 1'b0;
    hold_req = 1'b1;
    wait (hold_on);
    tx_idle  = 1'b0;
    repeat (HOLD_STRINGS) begin
      make_fen();
      send_string();
    end

    // Final stretch at full rate on both sides.
    idle_on = 1'b0;
    do begin
      make_fen();
      send_string();
    end while (chars_sent < ITEM_TARGET);
    char_valid <= 1'b0;

    while (word_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("fen_position_parser regression: pass");
    else
      $display("fen_position_parser regression: fail");
    $finish;
  end

endmodule
